/* hdl/ppcie_pkg.sv */
package ppcie_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SPR_COUNT  = 1024;

  localparam int SLOT_AW   = $clog2(SLOT_COUNT);
  localparam int SPR_AW    = $clog2(SPR_COUNT);
  localparam int SPR_CLR_W = $clog2(SPR_COUNT + 1);
  localparam int GPR_COUNT = 32;
  localparam int GPR_AW    = 5;

  localparam logic [9:0] SPR_XER = 10'd1;
  localparam logic [9:0] SPR_LR  = 10'd8;
  localparam logic [9:0] SPR_CTR = 10'd9;

  localparam int XER_SO_BIT = 31;
  localparam int XER_OV_BIT = 30;
  localparam int XER_CA_BIT = 29;

  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_LR     = 2'd1;
  localparam logic [1:0] KIND_CTR    = 2'd2;

  typedef enum logic [4:0] {
    OP_LOAD_GPR   = 5'd0,
    OP_STORE_GPR  = 5'd1,
    OP_LOAD_SPR   = 5'd2,
    OP_STORE_SPR  = 5'd3,
    OP_PC_REL     = 5'd4,
    OP_CONST_I32  = 5'd5,
    OP_ADD        = 5'd6,
    OP_SUB        = 5'd7,
    OP_ADD_CA     = 5'd8,
    OP_ADD_ECA    = 5'd9,
    OP_SUB_CA     = 5'd10,
    OP_SUB_ECA    = 5'd11,
    OP_MUL_LOW    = 5'd12,
    OP_MUL_HIGH_S = 5'd13,
    OP_MUL_HIGH_U = 5'd14,
    OP_MTCRF      = 5'd15,
    OP_AND        = 5'd16,
    OP_OR         = 5'd17,
    OP_XOR        = 5'd18,
    OP_ROTL_MASK  = 5'd19,
    OP_EXTS       = 5'd20,
    OP_SET_CR     = 5'd21,
    OP_BRANCH     = 5'd22
  } op_t;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  dest_slot;
    logic [9:0]  reg_index;
    logic [31:0] immediate;
    logic [7:0]  option_bits;
    logic [4:0]  rotate_amount;
    logic [4:0]  mask_begin;
    logic [4:0]  mask_end;
    logic [4:0]  branch_options;
    logic [15:0] insn_offset;
  } item_t;

  typedef struct packed {
    logic [31:0] cr;
    logic [31:0] xer;
    logic [31:0] lr;
    logic [31:0] ctr;
  } arch_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        branch_taken;
    logic [31:0] next_address;
    logic        block_end;
  } res_t;

  typedef struct packed {
    logic slot_we;
    logic gpr_we;
    logic spr_we;
  } wr_t;

  typedef logic [SLOT_AW-1:0] slot_map_t [256];

  // Slot numbers wrap modulo the store depth; the table is built at elaboration.
  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = SLOT_AW'(i % SLOT_COUNT);
    end
    return m;
  endfunction

  localparam slot_map_t SLOT_MAP = build_slot_map();

endpackage

/* hdl/ppcie_ram.sv */
module ppcie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ppcie_alu.sv */
module ppcie_alu (
  input  ppcie_pkg::item_t item,
  input  logic [31:0]      entry,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [31:0]      gpr_val,
  input  logic [31:0]      spr_val,
  input  ppcie_pkg::arch_t arch,
  output ppcie_pkg::arch_t arch_nxt,
  output ppcie_pkg::res_t  res,
  output ppcie_pkg::wr_t   wr
);

  logic [31:0]        add_x, add_y, add_d;
  logic               add_cin, add_co, add_ov;
  logic               mul_sgn, mul_ovf;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [31:0]        rot, mask_lo, mask_hi, mask_m;
  logic               spr_in_range;
  logic [31:0]        spr_rd;
  logic               cmp_lt, cmp_gt, cmp_eq;
  logic [31:0]        cmp_c;
  logic [31:0]        gpc, ctr_b;
  logic [1:0]         kind;
  logic               ok_ctr, ok_cnd, taken;
  logic [31:0]        xer_t;
  logic               oe;

  assign oe = item.option_bits[0];

  // Shared adder for all add and subtract forms.
  always_comb begin
    add_x   = (item.operation == ppcie_pkg::OP_SUB_ECA) ? ~a : a;
    add_y   = (item.operation == ppcie_pkg::OP_SUB ||
               item.operation == ppcie_pkg::OP_SUB_CA) ? ~b : b;
    add_cin = 1'b0;
    if (item.operation == ppcie_pkg::OP_SUB || item.operation == ppcie_pkg::OP_SUB_CA) begin
      add_cin = 1'b1;
    end else if (item.operation == ppcie_pkg::OP_ADD_ECA ||
                 item.operation == ppcie_pkg::OP_SUB_ECA) begin
      add_cin = arch.xer[ppcie_pkg::XER_CA_BIT];
    end
    {add_co, add_d} = 33'(add_x) + 33'(add_y) + 33'(add_cin);
    add_ov = ((add_x ^ ~add_y) & (add_x ^ add_d)) >> 31 != 32'd0;
  end

  assign mul_sgn = (item.operation != ppcie_pkg::OP_MUL_HIGH_U);
  assign mul_a   = {mul_sgn & a[31], a};
  assign mul_b   = {mul_sgn & b[31], b};
  assign prod    = mul_a * mul_b;
  assign mul_ovf = !((prod[63:31] == '0) || (prod[63:31] == '1));

  always_comb begin
    rot     = 32'(({a, a} << item.rotate_amount) >> 32);
    mask_lo = 32'hFFFF_FFFF >> item.mask_begin;
    mask_hi = (item.mask_end == 5'd31) ? 32'd0 :
              32'hFFFF_FFFF >> (6'(item.mask_end) + 6'd1);
    mask_m  = (item.mask_end < item.mask_begin) ? ~(mask_lo ^ mask_hi) : (mask_lo ^ mask_hi);
  end

  always_comb begin
    spr_in_range = (32'(item.reg_index) < 32'(ppcie_pkg::SPR_COUNT));
    if (item.reg_index == ppcie_pkg::SPR_XER) begin
      spr_rd = arch.xer;
    end else if (item.reg_index == ppcie_pkg::SPR_LR) begin
      spr_rd = arch.lr;
    end else if (item.reg_index == ppcie_pkg::SPR_CTR) begin
      spr_rd = arch.ctr;
    end else begin
      spr_rd = spr_in_range ? spr_val : 32'd0;
    end
  end

  always_comb begin
    cmp_eq = (a == b);
    cmp_lt = item.option_bits[1] ? ($signed(a) < $signed(b)) : (a < b);
    cmp_gt = !cmp_eq && !cmp_lt;
    cmp_c  = {cmp_lt, cmp_gt, cmp_eq, arch.xer[ppcie_pkg::XER_SO_BIT], 28'd0};
  end

  // Branch: target base, counter decrement, counter and condition tests.
  always_comb begin
    gpc    = entry + 32'(item.insn_offset);
    kind   = item.option_bits[7:6];
    ctr_b  = (!item.branch_options[2] && kind != ppcie_pkg::KIND_CTR) ?
             arch.ctr - 32'd1 : arch.ctr;
    ok_ctr = item.branch_options[2] || ((ctr_b != 32'd0) == !item.branch_options[1]);
    ok_cnd = item.branch_options[4] ||
             ((arch.cr[5'd31 - item.reg_index[4:0]] == 1'b0) == !item.branch_options[3]);
    taken  = ok_ctr && ok_cnd;
  end

  always_comb begin
    arch_nxt = arch;
    res      = '0;
    wr       = '0;
    xer_t    = arch.xer;
    unique case (item.operation) inside
      ppcie_pkg::OP_LOAD_GPR: begin
        res.result_value = gpr_val;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_STORE_GPR: begin
        res.result_value = a;
        wr.gpr_we        = 1'b1;
      end
      ppcie_pkg::OP_LOAD_SPR: begin
        res.result_value = spr_rd;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_STORE_SPR: begin
        res.result_value = a;
        if (item.reg_index == ppcie_pkg::SPR_XER) begin
          arch_nxt.xer = a;
        end else if (item.reg_index == ppcie_pkg::SPR_LR) begin
          arch_nxt.lr = a;
        end else if (item.reg_index == ppcie_pkg::SPR_CTR) begin
          arch_nxt.ctr = a;
        end else begin
          wr.spr_we = spr_in_range;
        end
      end
      ppcie_pkg::OP_PC_REL: begin
        res.result_value = entry + item.immediate;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_CONST_I32: begin
        res.result_value = item.immediate;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_ADD, ppcie_pkg::OP_SUB, ppcie_pkg::OP_ADD_CA, ppcie_pkg::OP_ADD_ECA,
      ppcie_pkg::OP_SUB_CA, ppcie_pkg::OP_SUB_ECA: begin
        res.result_value = add_d;
        wr.slot_we       = 1'b1;
        if (item.operation != ppcie_pkg::OP_ADD && item.operation != ppcie_pkg::OP_SUB) begin
          xer_t[ppcie_pkg::XER_CA_BIT] = add_co;
        end
        if (oe) begin
          xer_t[ppcie_pkg::XER_OV_BIT] = add_ov;
          if (add_ov) begin
            xer_t[ppcie_pkg::XER_SO_BIT] = 1'b1;
          end
        end
        arch_nxt.xer = xer_t;
      end
      ppcie_pkg::OP_MUL_LOW: begin
        res.result_value = prod[31:0];
        wr.slot_we       = 1'b1;
        if (oe) begin
          xer_t[ppcie_pkg::XER_OV_BIT] = mul_ovf;
          if (mul_ovf) begin
            xer_t[ppcie_pkg::XER_SO_BIT] = 1'b1;
          end
        end
        arch_nxt.xer = xer_t;
      end
      ppcie_pkg::OP_MUL_HIGH_S, ppcie_pkg::OP_MUL_HIGH_U: begin
        res.result_value = prod[63:32];
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_MTCRF: begin
        arch_nxt.cr      = (arch.cr & ~item.immediate) | (a & item.immediate);
        res.result_value = arch_nxt.cr;
      end
      ppcie_pkg::OP_AND: begin
        res.result_value = a & b;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_OR: begin
        res.result_value = a | b;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_XOR: begin
        res.result_value = a ^ b;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_ROTL_MASK: begin
        res.result_value = rot & mask_m;
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_EXTS: begin
        res.result_value = item.option_bits[5] ? {{24{a[7]}}, a[7:0]} : {{16{a[15]}}, a[15:0]};
        wr.slot_we       = 1'b1;
      end
      ppcie_pkg::OP_SET_CR: begin
        arch_nxt.cr = (arch.cr & ~(32'hF000_0000 >> item.reg_index[4:0])) |
                      (cmp_c >> item.reg_index[4:0]);
        res.result_value = arch_nxt.cr;
      end
      ppcie_pkg::OP_BRANCH: begin
        arch_nxt.ctr     = ctr_b;
        res.branch_taken = taken;
        if (taken) begin
          if (kind == ppcie_pkg::KIND_LR) begin
            res.next_address = arch.lr & ~32'd3;
          end else if (kind == ppcie_pkg::KIND_CTR) begin
            res.next_address = ctr_b & ~32'd3;
          end else begin
            res.next_address = item.option_bits[3] ? item.immediate : gpc + item.immediate;
          end
        end
        if (item.option_bits[2]) begin
          res.result_value = gpc + 32'd4;
          arch_nxt.lr      = gpc + 32'd4;
        end
        res.block_end = !(item.option_bits[4] && !taken);
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/ppc_ir_integer_execute_top.sv */
// Integer execute unit for an SSA-style intermediate representation of guest
// PowerPC code. One input transfer carries one instruction; one output transfer
// carries its result value, the condition register, the XER flags and the
// branch outcome. The user must write the entry address register through
// cfg_write_enable and cfg_write_data while the unit is idle (not enforced).
//
// An instruction is accepted while its operand slots and the GPR and SPR
// memories are read. It then executes against that data and writes back once
// the output register can take its result, and its result transfer is offered
// from that register. Once clearing is done, one instruction is taken every
// cycle while the receiver does not stall; a result written back in the same
// cycle as a dependent read is forwarded, so there is no dependency penalty.
//
// After reset the unit clears every entry of the SPR memory to zero, with
// in_stall held high. When the receiver stalls, the finished result waits
// in the output register and one more instruction may still be accepted and
// read; further instructions are then stalled until the output moves.
module ppc_ir_integer_execute_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic [7:0]  in_dest_slot,
  input  logic [7:0]  in_src_a,
  input  logic [7:0]  in_src_b,
  input  logic [9:0]  in_reg_index,
  input  logic [31:0] in_immediate,
  input  logic [7:0]  in_option_bits,
  input  logic [4:0]  in_rotate_amount,
  input  logic [4:0]  in_mask_begin,
  input  logic [4:0]  in_mask_end,
  input  logic [4:0]  in_branch_options,
  input  logic [15:0] in_insn_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic [31:0] out_cr_value,
  output logic [2:0]  out_xer_flags,
  output logic        out_branch_taken,
  output logic [31:0] out_next_address,
  output logic        out_block_end
);

  localparam int SAW = ppcie_pkg::SLOT_AW;
  localparam int PAW = ppcie_pkg::SPR_AW;
  localparam int GAW = ppcie_pkg::GPR_AW;

  // Handshake and pipeline control.
  logic accept, fire, clearing;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  // Instruction held in the execute stage.
  ppcie_pkg::item_t item_in, item_r;
  logic [SAW-1:0]   dest_addr_r;
  logic [SAW-1:0]   src_a_addr, src_b_addr, dest_addr_in;

  // Forwarding of write-backs that coincide with the operand reads.
  logic        fwd_a_hit, fwd_b_hit, fwd_gpr_hit, fwd_spr_hit;
  logic        fwd_a_r, fwd_b_r, fwd_gpr_r, fwd_spr_r;
  logic [31:0] fwd_slot_data_r, fwd_reg_data_r;
  logic        gpr_vld_s1_r;

  // Architectural state and its update.
  ppcie_pkg::arch_t arch_r, arch_nxt;
  logic [ppcie_pkg::GPR_COUNT-1:0] gpr_vld_r;
  logic [31:0] entry_r;
  logic [ppcie_pkg::SPR_CLR_W-1:0] clr_cnt_r;

  // Memory read data and the operands built from it.
  logic [31:0] slot_a_rd, slot_b_rd, gpr_rd, spr_rd;
  logic [31:0] op_a, op_b, gpr_val, spr_val;

  ppcie_pkg::res_t res;
  ppcie_pkg::wr_t  wr;
  ppcie_pkg::res_t out_res_r;
  logic [31:0]     out_cr_r;
  logic [2:0]      out_xer_r;

  logic           spr_we;
  logic [PAW-1:0] spr_waddr;
  logic [31:0]    spr_wdata;

  assign clearing = (32'(clr_cnt_r) < 32'(ppcie_pkg::SPR_COUNT));
  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing || (s1_valid_r && !fire);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_in.operation      = in_operation;
    item_in.dest_slot      = in_dest_slot;
    item_in.reg_index      = in_reg_index;
    item_in.immediate      = in_immediate;
    item_in.option_bits    = in_option_bits;
    item_in.rotate_amount  = in_rotate_amount;
    item_in.mask_begin     = in_mask_begin;
    item_in.mask_end       = in_mask_end;
    item_in.branch_options = in_branch_options;
    item_in.insn_offset    = in_insn_offset;
  end

  assign src_a_addr   = ppcie_pkg::SLOT_MAP[in_src_a];
  assign src_b_addr   = ppcie_pkg::SLOT_MAP[in_src_b];
  assign dest_addr_in = ppcie_pkg::SLOT_MAP[in_dest_slot];

  // The memories read the old word when written in the same cycle, so a
  // write-back from the executing instruction to an entry being read now is
  // captured here and replaces the stale read data in the next cycle.
  assign fwd_a_hit   = fire && wr.slot_we && (dest_addr_r == src_a_addr);
  assign fwd_b_hit   = fire && wr.slot_we && (dest_addr_r == src_b_addr);
  assign fwd_gpr_hit = fire && wr.gpr_we && (item_r.reg_index[GAW-1:0] == in_reg_index[GAW-1:0]);
  assign fwd_spr_hit = fire && wr.spr_we && (item_r.reg_index == in_reg_index);

  assign op_a    = fwd_a_r ? fwd_slot_data_r : slot_a_rd;
  assign op_b    = fwd_b_r ? fwd_slot_data_r : slot_b_rd;
  assign gpr_val = fwd_gpr_r ? fwd_reg_data_r : (gpr_vld_s1_r ? gpr_rd : 32'd0);
  assign spr_val = fwd_spr_r ? fwd_reg_data_r : spr_rd;

  ppcie_ram #(.WIDTH(32), .DEPTH(ppcie_pkg::SLOT_COUNT)) u_slot_a_ram (
    .clk   (clk),
    .we    (fire && wr.slot_we),
    .waddr (dest_addr_r),
    .wdata (res.result_value),
    .re    (accept),
    .raddr (src_a_addr),
    .rdata (slot_a_rd)
  );

  ppcie_ram #(.WIDTH(32), .DEPTH(ppcie_pkg::SLOT_COUNT)) u_slot_b_ram (
    .clk   (clk),
    .we    (fire && wr.slot_we),
    .waddr (dest_addr_r),
    .wdata (res.result_value),
    .re    (accept),
    .raddr (src_b_addr),
    .rdata (slot_b_rd)
  );

  ppcie_ram #(.WIDTH(32), .DEPTH(ppcie_pkg::GPR_COUNT)) u_gpr_ram (
    .clk   (clk),
    .we    (fire && wr.gpr_we),
    .waddr (item_r.reg_index[GAW-1:0]),
    .wdata (op_a),
    .re    (accept),
    .raddr (in_reg_index[GAW-1:0]),
    .rdata (gpr_rd)
  );

  // The clearing sweep after reset owns the SPR write port.
  assign spr_we    = clearing || (fire && wr.spr_we);
  assign spr_waddr = clearing ? clr_cnt_r[PAW-1:0] : item_r.reg_index[PAW-1:0];
  assign spr_wdata = clearing ? 32'd0 : op_a;

  ppcie_ram #(.WIDTH(32), .DEPTH(ppcie_pkg::SPR_COUNT)) u_spr_ram (
    .clk   (clk),
    .we    (spr_we),
    .waddr (spr_waddr),
    .wdata (spr_wdata),
    .re    (accept),
    .raddr (in_reg_index[PAW-1:0]),
    .rdata (spr_rd)
  );

  ppcie_alu u_alu (
    .item     (item_r),
    .entry    (entry_r),
    .a        (op_a),
    .b        (op_b),
    .gpr_val  (gpr_val),
    .spr_val  (spr_val),
    .arch     (arch_r),
    .arch_nxt (arch_nxt),
    .res      (res),
    .wr       (wr)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      arch_r      <= '0;
      gpr_vld_r   <= '0;
      entry_r     <= 32'd0;
      clr_cnt_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_write_enable) begin
        entry_r <= cfg_write_data;
      end
      if (fire) begin
        arch_r <= arch_nxt;
        if (wr.gpr_we) begin
          gpr_vld_r[item_r.reg_index[GAW-1:0]] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r          <= item_in;
      dest_addr_r     <= dest_addr_in;
      fwd_a_r         <= fwd_a_hit;
      fwd_b_r         <= fwd_b_hit;
      fwd_gpr_r       <= fwd_gpr_hit;
      fwd_spr_r       <= fwd_spr_hit;
      fwd_slot_data_r <= res.result_value;
      fwd_reg_data_r  <= op_a;
      gpr_vld_s1_r    <= gpr_vld_r[in_reg_index[GAW-1:0]];
    end
    if (fire) begin
      out_res_r <= res;
      out_cr_r  <= arch_nxt.cr;
      out_xer_r <= arch_nxt.xer[ppcie_pkg::XER_SO_BIT:ppcie_pkg::XER_CA_BIT];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r.result_value;
  assign out_cr_value     = out_cr_r;
  assign out_xer_flags    = out_xer_r;
  assign out_branch_taken = out_res_r.branch_taken;
  assign out_next_address = out_res_r.next_address;
  assign out_block_end    = out_res_r.block_end;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Testbench for the integer execute unit. A directed table runs first; it covers
// the field extremes, every operation but the GPR and SPR stores, and the corner
// cases of carries, masks, compares and branches. Random instruction streams
// follow, built mostly from slots that have already been written. An in-bench
// predictor keeps its own copy of the slots, GPRs, SPRs, CR and entry address.
// Each accepted instruction pushes one expected result onto a queue, and each
// output transfer is compared field by field with the oldest entry.
module tb;

  // Operation code outside the defined set; the unit must leave all state alone.
  localparam logic [4:0] OP_UNUSED = 5'd31;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_enable;
  logic [31:0] cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_operation;
  logic [7:0]  in_dest_slot;
  logic [7:0]  in_src_a;
  logic [7:0]  in_src_b;
  logic [9:0]  in_reg_index;
  logic [31:0] in_immediate;
  logic [7:0]  in_option_bits;
  logic [4:0]  in_rotate_amount;
  logic [4:0]  in_mask_begin;
  logic [4:0]  in_mask_end;
  logic [4:0]  in_branch_options;
  logic [15:0] in_insn_offset;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_value;
  logic [31:0] out_cr_value;
  logic [2:0]  out_xer_flags;
  logic        out_branch_taken;
  logic [31:0] out_next_address;
  logic        out_block_end;

  ppc_ir_integer_execute_top uut (.*);

  // One instruction, with the source slots added to the package item layout.
  typedef struct {
    logic [4:0]  op;
    logic [7:0]  dst;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [9:0]  reg_n;
    logic [31:0] imm;
    logic [7:0]  opt;
    logic [4:0]  sh;
    logic [4:0]  mb;
    logic [4:0]  me;
    logic [4:0]  bo;
    logic [15:0] off;
  } insn_t;

  // One expected result, field for field as the unit reports it.
  typedef struct {
    logic [31:0] value;
    logic [31:0] cr;
    logic [2:0]  xer;
    logic        taken;
    logic [31:0] target;
    logic        bend;
  } outcome_t;

  // Predicted architectural state.
  logic [31:0] slot_mem [256];
  bit          slot_written [256];
  logic [31:0] gpr_mem [32];
  logic [31:0] spr_mem [1024];
  logic [31:0] cr_reg;
  logic [31:0] entry_addr;

  outcome_t pending_results[$];
  int       fail_count;
  int       result_count;
  int       branch_count;
  int       taken_count;
  bit       stim_done;
  bit       hold_off;

  // Counts a mismatch and prints a single line about it.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("MISMATCH result %0d %s: got %h, expected %h", result_count, field, got, want);
  endtask

  function automatic logic [31:0] mask_between(logic [4:0] mb, logic [4:0] me);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] m;
    lo = 32'hFFFF_FFFF >> mb;
    hi = (me == 5'd31) ? 32'd0 : 32'hFFFF_FFFF >> (me + 1);
    m  = lo ^ hi;
    return (me < mb) ? ~m : m;
  endfunction

  function automatic void set_ov(bit ov);
    if (ov) begin
      spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_SO_BIT] = 1'b1;
    end
    spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_OV_BIT] = ov;
  endfunction

  // Works out the result of one instruction and advances the predicted state.
  function automatic outcome_t execute_insn(insn_t t);
    outcome_t    o;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    logic [32:0] wide;
    logic        ca;
    logic signed [63:0] ps;
    logic [63:0] pu;
    logic [31:0] c;
    logic [31:0] gpc;
    logic [1:0]  kind;
    bit          ok_ctr;
    bit          ok_cnd;
    bit          wr_slot;
    a = slot_mem[t.sa];
    b = slot_mem[t.sb];
    ca = spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_CA_BIT];
    o = '{default: '0};
    wr_slot = 1'b1;
    d = 32'd0;
    case (t.op) inside
      ppcie_pkg::OP_LOAD_GPR:   d = gpr_mem[t.reg_n[4:0]];
      ppcie_pkg::OP_STORE_GPR: begin
        d = a;
        gpr_mem[t.reg_n[4:0]] = a;
        wr_slot = 1'b0;
      end
      ppcie_pkg::OP_LOAD_SPR:   d = spr_mem[t.reg_n];
      ppcie_pkg::OP_STORE_SPR: begin
        d = a;
        spr_mem[t.reg_n] = a;
        wr_slot = 1'b0;
      end
      ppcie_pkg::OP_PC_REL:     d = entry_addr + t.imm;
      ppcie_pkg::OP_CONST_I32:  d = t.imm;
      ppcie_pkg::OP_ADD, ppcie_pkg::OP_ADD_CA, ppcie_pkg::OP_ADD_ECA: begin
        wide = {1'b0, a} + {1'b0, b} + ((t.op == ppcie_pkg::OP_ADD_ECA) ? 33'(ca) : 33'd0);
        d = wide[31:0];
        if (t.op != ppcie_pkg::OP_ADD) begin
          spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_CA_BIT] = wide[32];
        end
        if (t.opt[0]) begin
          set_ov(((a ^ ~b) & (a ^ d)) >> 31 != 0);
        end
      end
      ppcie_pkg::OP_SUB, ppcie_pkg::OP_SUB_CA: begin
        d = a - b;
        if (t.op == ppcie_pkg::OP_SUB_CA) begin
          spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_CA_BIT] = (a >= b);
        end
        if (t.opt[0]) begin
          set_ov(((a ^ b) & (a ^ d)) >> 31 != 0);
        end
      end
      ppcie_pkg::OP_SUB_ECA: begin
        wide = {1'b0, ~a} + {1'b0, b} + 33'(ca);
        d = wide[31:0];
        spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_CA_BIT] = wide[32];
        if (t.opt[0]) begin
          set_ov(((b ^ a) & (b ^ d)) >> 31 != 0);
        end
      end
      ppcie_pkg::OP_MUL_LOW, ppcie_pkg::OP_MUL_HIGH_S: begin
        ps = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        d = (t.op == ppcie_pkg::OP_MUL_LOW) ? ps[31:0] : ps[63:32];
        if (t.op == ppcie_pkg::OP_MUL_LOW && t.opt[0]) begin
          set_ov(ps[63:31] != '0 && ps[63:31] != '1);
        end
      end
      ppcie_pkg::OP_MUL_HIGH_U: begin
        pu = {32'd0, a} * {32'd0, b};
        d = pu[63:32];
      end
      ppcie_pkg::OP_MTCRF: begin
        cr_reg = (cr_reg & ~t.imm) | (a & t.imm);
        d = cr_reg;
        wr_slot = 1'b0;
      end
      ppcie_pkg::OP_AND:        d = a & b;
      ppcie_pkg::OP_OR:         d = a | b;
      ppcie_pkg::OP_XOR:        d = a ^ b;
      ppcie_pkg::OP_ROTL_MASK:
        d = ((a << t.sh) | (a >> ((32 - t.sh) % 32))) & mask_between(t.mb, t.me);
      ppcie_pkg::OP_EXTS:       d = t.opt[5] ? {{24{a[7]}}, a[7:0]} : {{16{a[15]}}, a[15:0]};
      ppcie_pkg::OP_SET_CR: begin
        if (t.opt[1]) begin
          c = ($signed(a) == $signed(b)) ? 32'h2000_0000 :
              ($signed(a) > $signed(b)) ? 32'h4000_0000 : 32'h8000_0000;
        end else begin
          c = (a == b) ? 32'h2000_0000 : (a > b) ? 32'h4000_0000 : 32'h8000_0000;
        end
        c = c + ({spr_mem[ppcie_pkg::SPR_XER][ppcie_pkg::XER_SO_BIT], 31'd0} >> 3);
        cr_reg = (cr_reg & ~(32'hF000_0000 >> t.reg_n[4:0])) | (c >> t.reg_n[4:0]);
        d = cr_reg;
        wr_slot = 1'b0;
      end
      ppcie_pkg::OP_BRANCH: begin
        wr_slot = 1'b0;
        gpc = entry_addr + 32'(t.off);
        kind = t.opt[7:6];
        branch_count++;
        if (!t.bo[2] && kind != ppcie_pkg::KIND_CTR) begin
          spr_mem[ppcie_pkg::SPR_CTR] = spr_mem[ppcie_pkg::SPR_CTR] - 1;
        end
        ok_ctr = t.bo[2] || ((spr_mem[ppcie_pkg::SPR_CTR] != 0) == !t.bo[1]);
        ok_cnd = t.bo[4] || (cr_reg[31 - t.reg_n[4:0]] == t.bo[3]);
        if (ok_ctr && ok_cnd) begin
          o.taken = 1'b1;
          taken_count++;
          if (kind == ppcie_pkg::KIND_LR) begin
            o.target = spr_mem[ppcie_pkg::SPR_LR] & ~32'd3;
          end else if (kind == ppcie_pkg::KIND_CTR) begin
            o.target = spr_mem[ppcie_pkg::SPR_CTR] & ~32'd3;
          end else begin
            o.target = t.opt[3] ? t.imm : gpc + t.imm;
          end
        end
        if (t.opt[2]) begin
          d = gpc + 4;
          spr_mem[ppcie_pkg::SPR_LR] = d;
        end
        o.bend = !(t.opt[4] && !o.taken);
      end
      default: wr_slot = 1'b0;
    endcase
    if (wr_slot) begin
      slot_mem[t.dst] = d;
      slot_written[t.dst] = 1'b1;
    end
    o.value = d;
    o.cr = cr_reg;
    o.xer = spr_mem[ppcie_pkg::SPR_XER][31:29];
    return o;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Overall limit: the SPR clearing sweep, about 830 items each with a possible
  // idle gap before it, plus the long hold-off, taken many times over.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Directed table. Rows whose expected value is obvious carry it in typed_value.
  typedef struct {
    insn_t       t;
    bit          typed;
    logic [31:0] typed_value;
  } row_t;

  row_t table_rows[$];
  logic [31:0] typed_queue[$];
  bit          typed_flags[$];

  function automatic insn_t mk(logic [4:0] op, logic [7:0] dst, logic [7:0] sa,
                               logic [7:0] sb, logic [9:0] reg_n, logic [31:0] imm,
                               logic [7:0] opt);
    insn_t t;
    t = '{op: op, dst: dst, sa: sa, sb: sb, reg_n: reg_n, imm: imm, opt: opt,
          sh: 5'd0, mb: 5'd0, me: 5'd31, bo: 5'd20, off: 16'd0};
    return t;
  endfunction

  function automatic void add_row(insn_t t, bit typed, logic [31:0] v);
    row_t r;
    r.t = t;
    r.typed = typed;
    r.typed_value = v;
    table_rows.push_back(r);
  endfunction

  function automatic void build_table();
    insn_t t;
    // Reads after reset give zero; SPR numbers run to their maximum.
    add_row(mk(ppcie_pkg::OP_LOAD_GPR, 8'd10, 8'd0, 8'd0, 10'd1023, 32'd0, 8'd0), 1, 32'd0);
    add_row(mk(ppcie_pkg::OP_LOAD_SPR, 8'd11, 8'd0, 8'd0, 10'd1023, 32'd0, 8'd0), 1, 32'd0);
    add_row(mk(ppcie_pkg::OP_CONST_I32, 8'd0, 8'd0, 8'd0, 10'd0, 32'hFFFF_FFFF, 8'd0), 1,
            32'hFFFF_FFFF);
    add_row(mk(ppcie_pkg::OP_CONST_I32, 8'd255, 8'd0, 8'd0, 10'd0, 32'h8000_0000, 8'd0), 1,
            32'h8000_0000);
    add_row(mk(ppcie_pkg::OP_CONST_I32, 8'd1, 8'd0, 8'd0, 10'd0, 32'h7FFF_FFFF, 8'd0), 1,
            32'h7FFF_FFFF);
    add_row(mk(ppcie_pkg::OP_PC_REL, 8'd2, 8'd0, 8'd0, 10'd0, 32'hFFFF_FFFC, 8'd0), 0, 0);
    // Overflow and carry at the extremes; SO then sticks.
    add_row(mk(ppcie_pkg::OP_ADD, 8'd3, 8'd1, 8'd1, 10'd0, 32'd0, 8'hFF), 1, 32'hFFFF_FFFE);
    add_row(mk(ppcie_pkg::OP_ADD_CA, 8'd4, 8'd0, 8'd0, 10'd0, 32'd0, 8'd1), 1,
            32'hFFFF_FFFE);
    add_row(mk(ppcie_pkg::OP_ADD_ECA, 8'd5, 8'd0, 8'd255, 10'd0, 32'd0, 8'd1), 0, 0);
    add_row(mk(ppcie_pkg::OP_SUB, 8'd6, 8'd255, 8'd1, 10'd0, 32'd0, 8'd1), 1, 32'h0000_0001);
    add_row(mk(ppcie_pkg::OP_SUB_CA, 8'd7, 8'd1, 8'd0, 10'd0, 32'd0, 8'd0), 1,
            32'h8000_0000);
    add_row(mk(ppcie_pkg::OP_SUB_ECA, 8'd8, 8'd0, 8'd0, 10'd0, 32'd0, 8'd1), 0, 0);
    add_row(mk(ppcie_pkg::OP_MUL_LOW, 8'd9, 8'd255, 8'd255, 10'd0, 32'd0, 8'd1), 1, 32'd0);
    add_row(mk(ppcie_pkg::OP_MUL_HIGH_S, 8'd12, 8'd255, 8'd255, 10'd0, 32'd0, 8'd0), 1,
            32'h4000_0000);
    add_row(mk(ppcie_pkg::OP_MUL_HIGH_U, 8'd13, 8'd0, 8'd0, 10'd0, 32'd0, 8'd0), 1,
            32'hFFFF_FFFE);
    add_row(mk(ppcie_pkg::OP_MTCRF, 8'd0, 8'd1, 8'd0, 10'd0, 32'hFFFF_FFFF, 8'd0), 1,
            32'h7FFF_FFFF);
    add_row(mk(ppcie_pkg::OP_AND, 8'd14, 8'd0, 8'd1, 10'd0, 32'd0, 8'd0), 1, 32'h7FFF_FFFF);
    add_row(mk(ppcie_pkg::OP_OR, 8'd15, 8'd255, 8'd1, 10'd0, 32'd0, 8'd0), 1, 32'hFFFF_FFFF);
    add_row(mk(ppcie_pkg::OP_XOR, 8'd16, 8'd0, 8'd1, 10'd0, 32'd0, 8'd0), 1, 32'h8000_0000);
    // Wrapped mask (end before begin) and the largest rotate amount.
    t = mk(ppcie_pkg::OP_ROTL_MASK, 8'd17, 8'd255, 8'd0, 10'd0, 32'd0, 8'd0);
    t.sh = 5'd31;
    t.mb = 5'd31;
    t.me = 5'd0;
    add_row(t, 0, 0);
    add_row(mk(ppcie_pkg::OP_EXTS, 8'd18, 8'd0, 8'd0, 10'd0, 32'd0, 8'h20), 1, 32'hFFFF_FFFF);
    add_row(mk(ppcie_pkg::OP_EXTS, 8'd19, 8'd1, 8'd0, 10'd0, 32'd0, 8'd0), 1, 32'hFFFF_FFFF);
    // Compare with a field shift that is not a multiple of four.
    add_row(mk(ppcie_pkg::OP_SET_CR, 8'd0, 8'd255, 8'd1, 10'd1023, 32'd0, 8'h02), 0, 0);
    // Branches: CTR decrement, link, side exit, the direct target kind and kind three.
    t = mk(ppcie_pkg::OP_BRANCH, 8'd0, 8'd0, 8'd0, 10'd31, 32'h0000_0100, 8'h14);
    t.bo = 5'd0;
    t.off = 16'hFFFF;
    add_row(t, 0, 0);
    t = mk(ppcie_pkg::OP_BRANCH, 8'd0, 8'd0, 8'd0, 10'd0, 32'hFFFF_FFFF, 8'hDC);
    t.bo = 5'd31;
    add_row(t, 0, 0);
    add_row(mk(OP_UNUSED, 8'd20, 8'd0, 8'd0, 10'd0, 32'd0, 8'd0), 1, 32'd0);
  endfunction

  // Random instruction with every source slot already written.
  function automatic insn_t random_insn();
    insn_t       t;
    logic [7:0]  pick;
    int          tries;
    t.op = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(23, 31)) :
           5'($urandom_range(0, 22));
    t.dst = 8'($urandom);
    t.reg_n = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    t.imm = ($urandom_range(0, 3) == 0) ? {$urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'd0} |
            32'($urandom_range(0, 255)) : 32'($urandom);
    t.opt = 8'($urandom);
    t.sh = 5'($urandom);
    t.mb = 5'($urandom);
    t.me = 5'($urandom);
    t.bo = 5'($urandom);
    t.off = 16'($urandom);
    for (int k = 0; k < 2; k++) begin
      pick = 8'($urandom);
      tries = 0;
      while (!slot_written[pick] && tries < 300) begin
        pick = pick + 1;
        tries++;
      end
      if (k == 0) t.sa = pick;
      else t.sb = pick;
    end
    return t;
  endfunction

  // Drives one instruction and waits for its transfer; predicts it on acceptance.
  task automatic send_insn(insn_t t, bit typed, logic [31:0] typed_v);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= t.op;
    in_dest_slot      <= t.dst;
    in_src_a          <= t.sa;
    in_src_b          <= t.sb;
    in_reg_index      <= t.reg_n;
    in_immediate      <= t.imm;
    in_option_bits    <= t.opt;
    in_rotate_amount  <= t.sh;
    in_mask_begin     <= t.mb;
    in_mask_end       <= t.me;
    in_branch_options <= t.bo;
    in_insn_offset    <= t.off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_insn(t));
    typed_queue.push_back(typed_v);
    typed_flags.push_back(typed);
  endtask

  // Stops offering at once so that the last instruction is not taken twice.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entry(logic [31:0] v);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    entry_addr = v;
  endtask

  // Stimulus.
  initial begin
    insn_t t;
    logic [31:0] settings [4];
    rst_n = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    in_operation = '0;
    in_dest_slot = '0;
    in_src_a = '0;
    in_src_b = '0;
    in_reg_index = '0;
    in_immediate = '0;
    in_option_bits = '0;
    in_rotate_amount = '0;
    in_mask_begin = '0;
    in_mask_end = '0;
    in_branch_options = '0;
    in_insn_offset = '0;
    for (int i = 0; i < 256; i++) begin
      slot_mem[i] = '0;
      slot_written[i] = 1'b0;
    end
    foreach (gpr_mem[i]) gpr_mem[i] = '0;
    foreach (spr_mem[i]) spr_mem[i] = '0;
    cr_reg = '0;
    entry_addr = '0;
    fail_count = 0;
    result_count = 0;
    branch_count = 0;
    taken_count = 0;
    stim_done = 1'b0;
    hold_off = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs with the reset value of the entry address.
    build_table();
    foreach (table_rows[i]) begin
      send_insn(table_rows[i].t, table_rows[i].typed, table_rows[i].typed_value);
    end
    drain();

    settings[0] = 32'hFFFF_FFFF;
    settings[1] = 32'h0000_0000;
    settings[2] = 32'h8000_1000;
    settings[3] = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      write_entry(settings[ph]);
      for (int n = 0; n < 200; n++) begin
        if (ph == 1 && n == 50) begin
          hold_off = 1'b1;
        end
        t = random_insn();
        send_insn(t, 0, 0);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // Receiver: random stalls, with one long hold-off while the sender keeps going.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int c = 0; c < 60; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) begin
        hold = $urandom_range(3, 20);
      end else if ($urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 2);
      end else begin
        hold = 0;
      end
      out_stall <= (hold > 0);
      if (hold > 1) repeat (hold - 1) @(posedge clk);
    end
  end

  // Result checker: samples each output transfer at the clock edge.
  always @(posedge clk) begin
    outcome_t    want;
    logic [31:0] typed_v;
    bit          typed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("MISMATCH unexpected output transfer with value %h", out_result_value);
      end else begin
        want = pending_results.pop_front();
        typed_v = typed_queue.pop_front();
        typed = typed_flags.pop_front();
        if (typed && typed_v !== want.value)
          report_mismatch("typed value", want.value, typed_v);
        if (out_result_value !== want.value)
          report_mismatch("result_value", out_result_value, want.value);
        if (out_cr_value !== want.cr)
          report_mismatch("cr_value", out_cr_value, want.cr);
        if (out_xer_flags !== want.xer)
          report_mismatch("xer_flags", 32'(out_xer_flags), 32'(want.xer));
        if (out_branch_taken !== want.taken)
          report_mismatch("branch_taken", 32'(out_branch_taken), 32'(want.taken));
        if (out_next_address !== want.target)
          report_mismatch("next_address", out_next_address, want.target);
        if (out_block_end !== want.bend)
          report_mismatch("block_end", 32'(out_block_end), 32'(want.bend));
        result_count++;
      end
    end
  end

  // End of run: wait for the stimulus and the last results, then settle.
  initial begin
    wait (stim_done);
    repeat (20) @(posedge clk);
    $display("Checked %0d results over five entry-address settings.", result_count);
    $display("Branches executed: %0d, taken: %0d.", branch_count, taken_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ppcie_pkg.sv
hdl/ppcie_ram.sv
hdl/ppcie_alu.sv
hdl/ppc_ir_integer_execute_top.sv
bench/tb.sv
